// ----- rtl/aosat_pkg.sv -----
// Shared types, widths and constants for the box / oriented cube overlap unit.
// No dependencies; every rtl file imports this package.
package aosat_pkg;

    // fixed-point formats
    localparam int COORD_FRAC_BITS = 16;
    localparam int AXIS_FRAC_BITS  = 16;

    localparam int CRD_W  = 32;                     // coordinate field width
    localparam int AXC_W  = 18;                     // packed axis component width
    localparam int AX_W   = AXC_W + 1;              // axis component after negation
    localparam int NRM_W  = 18;                     // normal component width
    localparam int NLANE  = 15;                     // candidate axes

    // normaliser
    localparam int MAG_W   = AX_W - 1;              // |axis component|
    localparam int SUM_W   = 2 * MAG_W;             // sum of three squares
    localparam int SQI_W   = SUM_W + 16;            // radicand
    localparam int ROOT_W  = SQI_W / 2;             // root bits, one per stage
    localparam int SREM_W  = ROOT_W + 4;            // root remainder
    localparam int QB      = AXIS_FRAC_BITS + 2;    // quotient bits, one per stage
    localparam int NSH     = AXIS_FRAC_BITS + 9;    // 2 * m * 2^(AFB+8)
    localparam int NUM_W   = MAG_W + NSH;
    localparam int DVD_W   = ROOT_W + 1;            // divisor 2 * len
    localparam int DREM_W  = DVD_W + 1;
    localparam int NORM_LAT = 1 + ROOT_W + 1 + QB + 1;

    // projections
    localparam int EXT_W  = CRD_W + 1;
    localparam int OFF_W  = CRD_W + 3;
    localparam int NABS_W = AXIS_FRAC_BITS + 1;
    localparam int RA_W   = EXT_W + NABS_W;
    localparam int SP_W   = OFF_W + NRM_W;
    localparam int CB_W   = NRM_W + AXC_W;
    localparam int RA2_W  = RA_W + 2;
    localparam int SEP2_W = SP_W + 2;
    localparam int DK_W   = CB_W + 2;
    localparam int RB_W   = DK_W + 1;
    localparam int D2_W   = SEP2_W + 2;
    localparam int RB_SHL = (COORD_FRAC_BITS >= AXIS_FRAC_BITS) ?
                            COORD_FRAC_BITS - AXIS_FRAC_BITS : 0;
    localparam int RB_SHR = (COORD_FRAC_BITS >= AXIS_FRAC_BITS) ?
                            0 : AXIS_FRAC_BITS - COORD_FRAC_BITS;
    localparam int DEPTH_W = 31;

    typedef enum logic [1:0] {
        ST_OVERLAP   = 2'd0,
        ST_SEPARATED = 2'd1,
        ST_INVALID   = 2'd2
    } t_status;

    typedef logic [2:0][AX_W-1:0]  t_axis;
    typedef logic [2:0][NRM_W-1:0] t_nvec;

    typedef struct packed {
        logic [CRD_W-1:0]   box_min_x;
        logic [CRD_W-1:0]   box_min_y;
        logic [CRD_W-1:0]   box_min_z;
        logic [CRD_W-1:0]   box_max_x;
        logic [CRD_W-1:0]   box_max_y;
        logic [CRD_W-1:0]   box_max_z;
        logic [CRD_W-1:0]   cube_centre_x;
        logic [CRD_W-1:0]   cube_centre_y;
        logic [CRD_W-1:0]   cube_centre_z;
        logic [3*AXC_W-1:0] cube_axis_u;
        logic [3*AXC_W-1:0] cube_axis_v;
        logic [3*AXC_W-1:0] cube_axis_w;
    } t_in_word;

    typedef struct packed {
        t_status             status;
        logic [DEPTH_W-1:0]  depth;
        logic [NRM_W-1:0]    normal_x;
        logic [NRM_W-1:0]    normal_y;
        logic [NRM_W-1:0]    normal_z;
    } t_out_word;

endpackage

// ----- rtl/aabb_obb_sat_overlap_unit.sv -----
// Top level: separating-axis overlap test between an axis-aligned box and a unit cube.
// Depends on aosat_pkg and aosat_norm (one normaliser per candidate axis).
//
//  channel | valid   | stall   | word
//  --------+---------+---------+-----------
//  input   | i_valid | o_stall | i_word
//  output  | o_valid | i_stall | o_word
//
// One word per clock in both directions while nothing stalls. A word on its way to o_valid passes the input
// register, the NORM_LAT stages of the bit-per-stage root and divider pipelines, four
// projection stages, a four-level minimum tree, a result stage and the output register.
// Reset is synchronous, active low, and clears only the valid bits and the skid full flag.
// A stalled output word parks in a skid register; o_stall rises only while the skid is
// full, and then the whole pipeline holds.
module aabb_obb_sat_overlap_unit
    import aosat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    localparam int LAST = NORM_LAT + 9;   // result stage index in the valid chain

    typedef struct packed {
        logic                   inv;
        logic [2:0][EXT_W-1:0]  ext;
        logic [2:0][OFF_W-1:0]  off2;
        logic [2:0][2:0][AXC_W-1:0] cube;
    } t_ctx;

    typedef struct packed {
        logic             have;
        logic             sep;
        logic [D2_W-1:0]  d2;
        t_nvec            n;
    } t_cand;

    // earlier candidate wins ties; separation from either side sticks
    function automatic t_cand pick(input t_cand l, input t_cand r);
        t_cand res;
        if (l.have && (!r.have || $signed(l.d2) <= $signed(r.d2))) begin
            res = l;
        end else begin
            res = r;
        end
        res.sep = l.sep | r.sep;
        return res;
    endfunction

    logic            en;
    logic [LAST:0]   r_vld;
    t_in_word        r_in;
    t_ctx            c0;
    t_ctx            r_ctx [1:NORM_LAT];
    t_axis           lane_ax   [NLANE];
    t_nvec           lane_n    [NLANE];
    logic            lane_skip [NLANE];

    // projection stages, per lane
    logic [2:0][RA_W-1:0]       r_p1_ra  [NLANE];
    logic [2:0][SP_W-1:0]       r_p1_sp  [NLANE];
    logic [2:0][2:0][CB_W-1:0]  r_p1_cb  [NLANE];
    t_nvec                      r_p1_n   [NLANE];
    logic                       r_p1_skip[NLANE];
    logic [RA2_W-1:0]           r_p2_ra  [NLANE];
    logic [SEP2_W-1:0]          r_p2_sep [NLANE];
    logic [2:0][DK_W-1:0]       r_p2_dk  [NLANE];
    t_nvec                      r_p2_n   [NLANE];
    logic                       r_p2_skip[NLANE];
    logic [RA2_W-1:0]           r_p3_ra  [NLANE];
    logic [RB_W-1:0]            r_p3_rb  [NLANE];
    logic [SEP2_W-1:0]          r_p3_abs [NLANE];
    logic                       r_p3_neg [NLANE];
    t_nvec                      r_p3_n   [NLANE];
    logic                       r_p3_skip[NLANE];
    t_cand                      r_p4     [16];
    t_cand                      n_p4     [16];
    t_cand                      r_t1     [8];
    t_cand                      r_t2     [4];
    t_cand                      r_t3     [2];
    t_cand                      r_t4;
    logic [8:1]                 r_inv;
    t_out_word                  r_res;
    t_out_word                  n_res;

    t_out_word                  r_out;
    logic                       r_out_valid;
    t_out_word                  r_skid;
    logic                       r_skid_full;

    // the pipeline holds only while the skid register is occupied
    assign en      = !r_skid_full;
    assign o_stall = r_skid_full;

    // context shared by all lanes
    always_comb begin
        logic signed [CRD_W-1:0] mn [3];
        logic signed [CRD_W-1:0] mx [3];
        logic signed [CRD_W-1:0] ct [3];
        mn[0] = $signed(r_in.box_min_x); mn[1] = $signed(r_in.box_min_y);
        mn[2] = $signed(r_in.box_min_z);
        mx[0] = $signed(r_in.box_max_x); mx[1] = $signed(r_in.box_max_y);
        mx[2] = $signed(r_in.box_max_z);
        ct[0] = $signed(r_in.cube_centre_x); ct[1] = $signed(r_in.cube_centre_y);
        ct[2] = $signed(r_in.cube_centre_z);
        c0.inv = 1'b0;
        for (int i = 0; i < 3; i++) begin
            c0.inv     = c0.inv | (mn[i] > mx[i]);
            c0.ext[i]  = EXT_W'(mx[i]) - EXT_W'(mn[i]);
            c0.off2[i] = OFF_W'(mn[i]) + OFF_W'(mx[i]) - (OFF_W'(ct[i]) << 1);
            c0.cube[0][i] = r_in.cube_axis_u[AXC_W*i +: AXC_W];
            c0.cube[1][i] = r_in.cube_axis_v[AXC_W*i +: AXC_W];
            c0.cube[2][i] = r_in.cube_axis_w[AXC_W*i +: AXC_W];
        end
    end

    // candidate axes: world, cube, then world x cube
    always_comb begin
        logic signed [AX_W-1:0] r0, r1, r2;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                lane_ax[k][i]   = (i == k) ? (AX_W'(1) << AXIS_FRAC_BITS) : '0;
                lane_ax[3+k][i] = AX_W'($signed(c0.cube[k][i]));
            end
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                r0 = AX_W'($signed(c0.cube[i][0]));
                r1 = AX_W'($signed(c0.cube[i][1]));
                r2 = AX_W'($signed(c0.cube[i][2]));
                case (k)
                    0: begin
                        lane_ax[6+3*k+i] = {r1, -r2, AX_W'(0)};
                    end
                    1: begin
                        lane_ax[6+3*k+i] = {-r0, AX_W'(0), r2};
                    end
                    default: begin
                        lane_ax[6+3*k+i] = {AX_W'(0), r0, -r1};
                    end
                endcase
            end
        end
    end

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        aosat_norm u_norm (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_axis (lane_ax[l]),
            .o_n    (lane_n[l]),
            .o_skip (lane_skip[l])
        );
    end

    // projection arithmetic for all lanes
    t_ctx                      cl;
    logic [2:0][RA_W-1:0]      n_p1_ra  [NLANE];
    logic [2:0][SP_W-1:0]      n_p1_sp  [NLANE];
    logic [2:0][2:0][CB_W-1:0] n_p1_cb  [NLANE];
    logic [RA2_W-1:0]          n_p2_ra  [NLANE];
    logic [SEP2_W-1:0]         n_p2_sep [NLANE];
    logic [2:0][DK_W-1:0]      n_p2_dk  [NLANE];
    logic [RB_W-1:0]           n_p3_rb  [NLANE];
    logic [SEP2_W-1:0]         n_p3_abs [NLANE];

    assign cl = r_ctx[NORM_LAT];

    always_comb begin
        logic signed [NRM_W-1:0]  nv;
        logic [NABS_W-1:0]        nabs;
        logic signed [DK_W-1:0]   dks;
        logic signed [SEP2_W-1:0] ss;
        logic [D2_W-1:0]          d2;
        for (int l = 0; l < NLANE; l++) begin
            // multiply
            for (int i = 0; i < 3; i++) begin
                nv   = $signed(lane_n[l][i]);
                nabs = NABS_W'(nv < 0 ? -nv : nv);
                n_p1_ra[l][i] = RA_W'(cl.ext[i]) * RA_W'(nabs);
                n_p1_sp[l][i] = SP_W'($signed(cl.off2[i]) * nv);
                for (int k = 0; k < 3; k++) begin
                    n_p1_cb[l][k][i] = CB_W'(nv * $signed(cl.cube[k][i]));
                end
            end
            // sum
            n_p2_ra[l]  = RA2_W'(r_p1_ra[l][0]) + RA2_W'(r_p1_ra[l][1])
                        + RA2_W'(r_p1_ra[l][2]);
            n_p2_sep[l] = SEP2_W'($signed(r_p1_sp[l][0])) + SEP2_W'($signed(r_p1_sp[l][1]))
                        + SEP2_W'($signed(r_p1_sp[l][2]));
            for (int k = 0; k < 3; k++) begin
                n_p2_dk[l][k] = DK_W'($signed(r_p1_cb[l][k][0]))
                              + DK_W'($signed(r_p1_cb[l][k][1]))
                              + DK_W'($signed(r_p1_cb[l][k][2]));
            end
            // magnitudes
            n_p3_rb[l] = '0;
            for (int k = 0; k < 3; k++) begin
                dks = $signed(r_p2_dk[l][k]);
                n_p3_rb[l] = n_p3_rb[l] + RB_W'(dks < 0 ? -dks : dks);
            end
            ss = $signed(r_p2_sep[l]);
            n_p3_abs[l] = SEP2_W'(ss < 0 ? -ss : ss);
            // depth of this axis at full precision
            d2 = D2_W'(r_p3_ra[l]) + ((D2_W'(r_p3_rb[l]) << RB_SHL) >> RB_SHR)
               - D2_W'(r_p3_abs[l]);
            n_p4[l].have = !r_p3_skip[l];
            n_p4[l].sep  = !r_p3_skip[l] && d2[D2_W-1];
            n_p4[l].d2   = d2;
            for (int i = 0; i < 3; i++) begin
                n_p4[l].n[i] = r_p3_neg[l] ? NRM_W'(-$signed(r_p3_n[l][i])) : r_p3_n[l][i];
            end
        end
        n_p4[15] = '0;
    end

    // output word from the winning candidate
    always_comb begin
        logic [D2_W-1:0] rnd;
        logic [D2_W-1:0] dq;
        rnd = r_t4.d2 + (D2_W'(1) << AXIS_FRAC_BITS);
        dq  = rnd >> (AXIS_FRAC_BITS + 1);
        n_res = '0;
        if (r_inv[8]) begin
            n_res.status = ST_INVALID;
        end else if (r_t4.sep) begin
            n_res.status = ST_SEPARATED;
        end else begin
            n_res.status   = ST_OVERLAP;
            n_res.depth    = (dq > D2_W'({DEPTH_W{1'b1}})) ? {DEPTH_W{1'b1}} :
                             DEPTH_W'(dq);
            n_res.normal_x = r_t4.n[0];
            n_res.normal_y = r_t4.n[1];
            n_res.normal_z = r_t4.n[2];
        end
    end

    // datapath registers: advance together
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in     <= i_word;
            r_ctx[1] <= c0;
            for (int s = 1; s < NORM_LAT; s++) begin
                r_ctx[s+1] <= r_ctx[s];
            end
            r_p1_ra   <= n_p1_ra;
            r_p1_sp   <= n_p1_sp;
            r_p1_cb   <= n_p1_cb;
            r_p1_n    <= lane_n;
            r_p1_skip <= lane_skip;
            r_p2_ra   <= n_p2_ra;
            r_p2_sep  <= n_p2_sep;
            r_p2_dk   <= n_p2_dk;
            r_p2_n    <= r_p1_n;
            r_p2_skip <= r_p1_skip;
            r_p3_ra   <= r_p2_ra;
            r_p3_rb   <= n_p3_rb;
            r_p3_abs  <= n_p3_abs;
            for (int l = 0; l < NLANE; l++) begin
                r_p3_neg[l] <= r_p2_sep[l][SEP2_W-1];
            end
            r_p3_n    <= r_p2_n;
            r_p3_skip <= r_p2_skip;
            r_p4      <= n_p4;
            for (int t = 0; t < 8; t++) begin
                r_t1[t] <= pick(r_p4[2*t], r_p4[2*t+1]);
            end
            for (int t = 0; t < 4; t++) begin
                r_t2[t] <= pick(r_t1[2*t], r_t1[2*t+1]);
            end
            for (int t = 0; t < 2; t++) begin
                r_t3[t] <= pick(r_t2[2*t], r_t2[2*t+1]);
            end
            r_t4  <= pick(r_t3[0], r_t3[1]);
            r_inv <= {r_inv[7:1], cl.inv};
            r_res <= n_res;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_valid};
        end
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (!i_stall) begin
                r_skid_full <= 1'b0;
            end
        end else if (r_vld[LAST]) begin
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_full <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (r_vld[LAST]) begin
            if (!r_out_valid || !i_stall) begin
                r_out <= r_res;
            end else begin
                r_skid <= r_res;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    // a parked word always sits behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_valid)
        else $error("skid full with empty output register");

    // skid fills only from a stalled output word
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_full) |-> $past(r_out_valid && i_stall))
        else $error("skid filled without an output stall");

    // depth and normal are zero unless the shapes overlap
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.status != ST_OVERLAP) |->
        (o_word.depth == '0 && o_word.normal_x == '0 &&
         o_word.normal_y == '0 && o_word.normal_z == '0))
        else $error("non-zero depth or normal without overlap");

endmodule

// ----- rtl/aosat_norm.sv -----
// Axis normaliser: pipelined square root then three pipelined dividers.
// Depends on aosat_pkg; advances when i_en is high.
module aosat_norm
    import aosat_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_axis i_axis,
    output t_nvec o_n,
    output logic  o_skip
);

    // root stages
    logic [SQI_W-1:0]  r_sx    [0:ROOT_W];
    logic [SREM_W-1:0] r_srem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_sroot [0:ROOT_W];
    logic [2:0][MAG_W-1:0] r_smag [0:ROOT_W];
    logic [2:0]        r_sneg  [0:ROOT_W];
    logic              r_sskip [0:ROOT_W];
    logic [SQI_W-1:0]  n_sx    [0:ROOT_W];
    logic [SREM_W-1:0] n_srem  [0:ROOT_W];
    logic [ROOT_W-1:0] n_sroot [0:ROOT_W];
    logic [2:0][MAG_W-1:0] n_smag [0:ROOT_W];
    logic [2:0]        n_sneg  [0:ROOT_W];
    logic              n_sskip [0:ROOT_W];

    // divider stages
    logic [2:0][DREM_W-1:0] r_drem [0:QB];
    logic [2:0][QB-1:0]     r_dlow [0:QB];
    logic [2:0][QB-1:0]     r_dq   [0:QB];
    logic [DVD_W-1:0]       r_dd   [0:QB];
    logic [2:0]             r_dneg [0:QB];
    logic                   r_dskip[0:QB];
    logic [2:0][DREM_W-1:0] n_drem [0:QB];
    logic [2:0][QB-1:0]     n_dlow [0:QB];
    logic [2:0][QB-1:0]     n_dq   [0:QB];
    logic [DVD_W-1:0]       n_dd   [0:QB];
    logic [2:0]             n_dneg [0:QB];
    logic                   n_dskip[0:QB];

    t_nvec r_n;
    t_nvec n_n;
    logic  r_skip;

    always_comb begin
        logic signed [AX_W-1:0] a_s;
        logic [SUM_W-1:0]       sum;
        logic [SREM_W-1:0]      rem2;
        logic [SREM_W-1:0]      trial;
        logic [NUM_W-1:0]       num;
        logic [DREM_W-1:0]      drem2;
        logic [QB-1:0]          q;
        logic                   ge;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            a_s = $signed(i_axis[i]);
            n_sneg[0][i] = a_s < 0;
            n_smag[0][i] = MAG_W'(a_s < 0 ? -a_s : a_s);
            sum = sum + SUM_W'(n_smag[0][i] * n_smag[0][i]);
        end
        n_sx[0]    = {sum, 16'b0};
        n_srem[0]  = '0;
        n_sroot[0] = '0;
        n_sskip[0] = (sum == '0);
        // one root bit per stage
        for (int j = 0; j < ROOT_W; j++) begin
            rem2  = {r_srem[j][SREM_W-3:0], r_sx[j][SQI_W-1 -: 2]};
            trial = SREM_W'({r_sroot[j], 2'b01});
            ge    = rem2 >= trial;
            n_srem[j+1]  = ge ? rem2 - trial : rem2;
            n_sroot[j+1] = {r_sroot[j][ROOT_W-2:0], ge};
            n_sx[j+1]    = r_sx[j] << 2;
            n_smag[j+1]  = r_smag[j];
            n_sneg[j+1]  = r_sneg[j];
            n_sskip[j+1] = r_sskip[j];
        end
        // divider set-up: (2 m 2^(AFB+8) + len) / (2 len)
        n_dd[0]    = {r_sroot[ROOT_W], 1'b0};
        n_dneg[0]  = r_sneg[ROOT_W];
        n_dskip[0] = r_sskip[ROOT_W];
        for (int i = 0; i < 3; i++) begin
            num = (NUM_W'(r_smag[ROOT_W][i]) << NSH) + NUM_W'(r_sroot[ROOT_W]);
            n_drem[0][i] = DREM_W'(num[NUM_W-1:QB]);
            n_dlow[0][i] = num[QB-1:0];
            n_dq[0][i]   = '0;
        end
        // one quotient bit per stage
        for (int j = 0; j < QB; j++) begin
            for (int i = 0; i < 3; i++) begin
                drem2 = {r_drem[j][i][DREM_W-2:0], r_dlow[j][i][QB-1]};
                ge    = drem2 >= DREM_W'(r_dd[j]);
                n_drem[j+1][i] = ge ? drem2 - DREM_W'(r_dd[j]) : drem2;
                n_dlow[j+1][i] = r_dlow[j][i] << 1;
                n_dq[j+1][i]   = {r_dq[j][i][QB-2:0], ge};
            end
            n_dd[j+1]    = r_dd[j];
            n_dneg[j+1]  = r_dneg[j];
            n_dskip[j+1] = r_dskip[j];
        end
        // clamp to unit and restore sign
        for (int i = 0; i < 3; i++) begin
            q = r_dq[QB][i];
            if (q > (QB'(1) << AXIS_FRAC_BITS)) begin
                q = QB'(1) << AXIS_FRAC_BITS;
            end
            n_n[i] = r_dneg[QB][i] ? NRM_W'(-q) : NRM_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx    <= n_sx;
            r_srem  <= n_srem;
            r_sroot <= n_sroot;
            r_smag  <= n_smag;
            r_sneg  <= n_sneg;
            r_sskip <= n_sskip;
            r_drem  <= n_drem;
            r_dlow  <= n_dlow;
            r_dq    <= n_dq;
            r_dd    <= n_dd;
            r_dneg  <= n_dneg;
            r_dskip <= n_dskip;
            r_n     <= n_n;
            r_skip  <= r_dskip[QB];
        end
    end

    assign o_n    = r_n;
    assign o_skip = r_skip;

endmodule

// ----- sim/tb_aabb_obb_sat_overlap_unit.sv -----
// Self-checking testbench for the box / oriented cube separating-axis overlap unit.
// Depends on aosat_pkg and the rtl top level; holds its own fixed-point overlap predictor.
`timescale 1ns / 1ps

module tb_aabb_obb_sat_overlap_unit;
    import aosat_pkg::*;

    localparam int  ONE_U      = 1 << AXIS_FRAC_BITS;   // unit axis component
    localparam int  ONE_C      = 1 << COORD_FRAC_BITS;  // one coordinate unit
    localparam int  IDLE_LIMIT = 4000;                   // cycles with no word moving
    localparam int  DRAIN_WAIT = 80;                     // final drain wait in cycles, longer than the pipeline latency

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_word = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_word;

    aabb_obb_sat_overlap_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idling percentages for the current phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    t_out_word   pending_results[$];
    int unsigned fail_count = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned n_overlap = 0, n_separated = 0, n_invalid = 0;
    int unsigned idle_cycles = 0;

    // Working copy of one pair's geometry, used while predicting
    longint box_ext[3], box_off2[3], cube_ax[3][3];
    bit     have_axis;
    longint best_depth2;
    longint best_norm[3];

    function automatic longint isqrt64(longint x);
        longint r = 0;
        longint b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Project both shapes on one candidate axis; return 0 when it separates them.
    function automatic bit probe_axis(longint a0, longint a1, longint a2);
        longint a[3], n[3];
        longint s, len, m, q, ra, sep, rb, d, dd;
        a[0] = a0; a[1] = a1; a[2] = a2;
        s = a0 * a0 + a1 * a1 + a2 * a2;
        if (s == 0) return 1'b1;            // degenerate axis: skip
        len = isqrt64(s << 16);
        for (int i = 0; i < 3; i++) begin
            m = mag(a[i]);
            q = (2 * m * (longint'(1) << (AXIS_FRAC_BITS + 8)) + len) / (2 * len);
            if (q > ONE_U) q = ONE_U;
            n[i] = (a[i] < 0) ? -q : q;
        end
        ra = 0; sep = 0; rb = 0;
        for (int i = 0; i < 3; i++) begin
            ra  += box_ext[i] * mag(n[i]);
            sep += box_off2[i] * n[i];
        end
        for (int k = 0; k < 3; k++) begin
            d = 0;
            for (int i = 0; i < 3; i++) d += n[i] * cube_ax[k][i];
            rb += mag(d);
        end
        rb = (rb << RB_SHL) >> RB_SHR;
        dd = ra + rb - mag(sep);
        if (dd < 0) return 1'b0;
        if (!have_axis || dd < best_depth2) begin
            have_axis   = 1'b1;
            best_depth2 = dd;
            for (int i = 0; i < 3; i++) best_norm[i] = (sep >= 0) ? n[i] : -n[i];
        end
        return 1'b1;
    endfunction

    function automatic t_out_word predict_overlap(t_in_word w);
        t_out_word r;
        longint mn[3], mx[3], ctr[3], dep;
        logic [3*AXC_W-1:0] packed_ax[3];
        logic [NRM_W-1:0] nb[3];
        bit open;
        r = '0;
        mn[0] = $signed(w.box_min_x); mn[1] = $signed(w.box_min_y);
        mn[2] = $signed(w.box_min_z);
        mx[0] = $signed(w.box_max_x); mx[1] = $signed(w.box_max_y);
        mx[2] = $signed(w.box_max_z);
        ctr[0] = $signed(w.cube_centre_x); ctr[1] = $signed(w.cube_centre_y);
        ctr[2] = $signed(w.cube_centre_z);
        for (int i = 0; i < 3; i++) begin
            if (mn[i] > mx[i]) begin
                r.status = ST_INVALID;
                return r;
            end
        end
        packed_ax[0] = w.cube_axis_u; packed_ax[1] = w.cube_axis_v;
        packed_ax[2] = w.cube_axis_w;
        for (int i = 0; i < 3; i++) begin
            box_ext[i]  = mx[i] - mn[i];
            box_off2[i] = mn[i] + mx[i] - 2 * ctr[i];
        end
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                cube_ax[k][i] = $signed(packed_ax[k][AXC_W*i +: AXC_W]);
        have_axis = 1'b0; best_depth2 = 0;
        for (int i = 0; i < 3; i++) best_norm[i] = 0;
        // world axes, cube axes, then the nine cross products
        open = probe_axis(ONE_U, 0, 0) && probe_axis(0, ONE_U, 0) && probe_axis(0, 0, ONE_U);
        for (int k = 0; k < 3 && open; k++)
            open = probe_axis(cube_ax[k][0], cube_ax[k][1], cube_ax[k][2]);
        for (int k = 0; k < 3 && open; k++) begin
            for (int i = 0; i < 3 && open; i++) begin
                if (k == 0)      open = probe_axis(0, -cube_ax[i][2], cube_ax[i][1]);
                else if (k == 1) open = probe_axis(cube_ax[i][2], 0, -cube_ax[i][0]);
                else             open = probe_axis(-cube_ax[i][1], cube_ax[i][0], 0);
            end
        end
        if (!open) begin
            r.status = ST_SEPARATED;
            return r;
        end
        dep = (best_depth2 + (longint'(1) << AXIS_FRAC_BITS)) >> (AXIS_FRAC_BITS + 1);
        if (dep > 64'h7FFF_FFFF) dep = 64'h7FFF_FFFF;
        for (int i = 0; i < 3; i++) nb[i] = best_norm[i][NRM_W-1:0];
        r.status   = ST_OVERLAP;
        r.depth    = dep[DEPTH_W-1:0];
        r.normal_x = nb[0];
        r.normal_y = nb[1];
        r.normal_z = nb[2];
        return r;
    endfunction

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no prediction waiting");
                fail_count++;
            end else begin
                exp_w = pending_results.pop_front();
                words_checked++;
                case (exp_w.status)
                    ST_OVERLAP:   n_overlap++;
                    ST_SEPARATED: n_separated++;
                    default:      n_invalid++;
                endcase
                if (o_word.status !== exp_w.status) begin
                    $error("status: expected %0d got %0d", exp_w.status, o_word.status);
                    fail_count++;
                end
                if (o_word.depth !== exp_w.depth) begin
                    $error("depth: expected %0d got %0d", exp_w.depth, o_word.depth);
                    fail_count++;
                end
                if (o_word.normal_x !== exp_w.normal_x) begin
                    $error("normal_x: expected %0d got %0d",
                           $signed(exp_w.normal_x), $signed(o_word.normal_x));
                    fail_count++;
                end
                if (o_word.normal_y !== exp_w.normal_y) begin
                    $error("normal_y: expected %0d got %0d",
                           $signed(exp_w.normal_y), $signed(o_word.normal_y));
                    fail_count++;
                end
                if (o_word.normal_z !== exp_w.normal_z) begin
                    $error("normal_z: expected %0d got %0d",
                           $signed(exp_w.normal_z), $signed(o_word.normal_z));
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: end the run if no word moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Drive one input word, hold it until accepted, then optionally idle
    task automatic send_word(t_in_word w);
        i_word  <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results = {pending_results, predict_overlap(w)};
        words_sent++;
        @(negedge i_clk);
        while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic go_quiet();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic pause_until_drained();
        go_quiet();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [3*AXC_W-1:0] pack_axis(int x, int y, int z);
        logic [AXC_W-1:0] cx, cy, cz;
        cx = x[AXC_W-1:0]; cy = y[AXC_W-1:0]; cz = z[AXC_W-1:0];
        return {cz, cy, cx};
    endfunction

    function automatic t_in_word build_pair(int nx, int ny, int nz, int xx, int xy, int xz,
                                            int cx, int cy, int cz,
                                            logic [3*AXC_W-1:0] u,
                                            logic [3*AXC_W-1:0] v,
                                            logic [3*AXC_W-1:0] w);
        t_in_word t;
        t.box_min_x = nx; t.box_min_y = ny; t.box_min_z = nz;
        t.box_max_x = xx; t.box_max_y = xy; t.box_max_z = xz;
        t.cube_centre_x = cx; t.cube_centre_y = cy; t.cube_centre_z = cz;
        t.cube_axis_u = u; t.cube_axis_v = v; t.cube_axis_w = w;
        return t;
    endfunction

    function automatic logic [3*AXC_W-1:0] rand_axis();
        int c[3];
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 3) begin
            // signed unit vector along one world axis
            c = '{0, 0, 0};
            c[$urandom_range(2)] = $urandom_range(1) ? ONE_U : -ONE_U;
        end else if (pick == 3) begin
            c = '{0, 0, 0};                  // degenerate
        end else begin
            for (int i = 0; i < 3; i++) c[i] = $urandom_range(2 * ONE_U) - ONE_U;
        end
        return pack_axis(c[0], c[1], c[2]);
    endfunction

    // Mostly near-contact scenes, some invalid boxes and some fully random words
    function automatic t_in_word rand_pair();
        t_in_word t;
        logic [17*32-1:0] raw;
        int lo[3], hi[3], ce[3];
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 15) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom};
            t = raw[$bits(t_in_word)-1:0];
            return t;
        end
        for (int i = 0; i < 3; i++) begin
            lo[i] = $urandom_range(16 * ONE_C) - 8 * ONE_C;
            hi[i] = lo[i] + $urandom_range(4 * ONE_C);
            ce[i] = lo[i] + $urandom_range(8 * ONE_C) - 2 * ONE_C;
        end
        if (kind < 22) begin
            int k;
            k = $urandom_range(2);
            hi[k] = lo[k] - 1 - $urandom_range(ONE_C);   // min above max
        end
        return build_pair(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], ce[0], ce[1], ce[2],
                          rand_axis(), rand_axis(), rand_axis());
    endfunction

    task automatic check_corner_cases();
        logic [3*AXC_W-1:0] ex, ey, ez, zr;
        int big, tiny;
        ex = pack_axis(ONE_U, 0, 0);
        ey = pack_axis(0, ONE_U, 0);
        ez = pack_axis(0, 0, ONE_U);
        zr = '0;
        big = 32'h7FFF_FFFF; tiny = 32'h8000_0000;
        send_idle_pct = 0; recv_stall_pct = 0;
        // cube centred in unit box: ties everywhere, earliest axis wins
        send_word(build_pair(-ONE_C, -ONE_C, -ONE_C, ONE_C, ONE_C, ONE_C, 0, 0, 0,
                             ex, ey, ez));
        // far apart: separated
        send_word(build_pair(0, 0, 0, ONE_C, ONE_C, ONE_C, 10 * ONE_C, 0, 0, ex, ey, ez));
        // just touching on x: zero depth still overlaps
        send_word(build_pair(0, 0, 0, ONE_C, ONE_C, ONE_C, -ONE_C / 2, ONE_C / 2, ONE_C / 2,
                             ex, ey, ez));
        // cube on the far side: offset negative, normal flips
        send_word(build_pair(0, 0, 0, ONE_C, ONE_C, ONE_C, 3 * ONE_C / 2 - 8, ONE_C / 2,
                             ONE_C / 2, ex, ey, ez));
        // point box at origin
        send_word(build_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, ex, ey, ez));
        // whole coordinate range: depth saturates
        send_word(build_pair(tiny, tiny, tiny, big, big, big, 0, 0, 0, ex, ey, ez));
        send_word(build_pair(tiny, tiny, tiny, big, big, big, big, tiny, big, ex, ey, ez));
        // invalid box on each axis
        send_word(build_pair(ONE_C, 0, 0, 0, ONE_C, ONE_C, 0, 0, 0, ex, ey, ez));
        send_word(build_pair(0, ONE_C, 0, ONE_C, 0, ONE_C, 0, 0, 0, ex, ey, ez));
        send_word(build_pair(0, 0, big, ONE_C, ONE_C, tiny, 0, 0, 0, ex, ey, ez));
        // all cube axes degenerate: only world axes count
        send_word(build_pair(-ONE_C, -ONE_C, -ONE_C, ONE_C, ONE_C, ONE_C, ONE_C / 4, 0, 0,
                             zr, zr, zr));
        // extreme axis codes: most negative and most positive components
        send_word(build_pair(-ONE_C, -ONE_C, -ONE_C, ONE_C, ONE_C, ONE_C, 0, 0, 0,
                             pack_axis(-131072, -131072, -131072),
                             pack_axis(131071, 131071, 131071),
                             pack_axis(-131072, 131071, 0)));
        // rotated cube near a corner
        send_word(build_pair(0, 0, 0, 2 * ONE_C, 2 * ONE_C, 2 * ONE_C, -ONE_C / 2, 0, 0,
                             pack_axis(46341, 46341, 0), pack_axis(-46341, 46341, 0), ez));
        send_word(build_pair(0, 0, 0, ONE_C, ONE_C, ONE_C, -ONE_C / 2 - 5000, ONE_C / 2,
                             ONE_C / 2, pack_axis(46341, 0, 46341), ey,
                             pack_axis(-46341, 0, 46341)));
        // all ones and all zeros words
        send_word('0);
        send_word('1);
        pause_until_drained();
    endtask

    task automatic run_random_phase(int unsigned count, int unsigned snd_pct,
                                    int unsigned rcv_pct);
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        for (int unsigned n = 0; n < count; n++) begin
            send_word(rand_pair());
            // hold off once mid-phase until the pipeline empties
            if (n == count / 2) pause_until_drained();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        check_corner_cases();
        run_random_phase(260, 0, 0);
        run_random_phase(260, 68, 0);
        run_random_phase(260, 0, 68);
        run_random_phase(260, 7, 7);
        go_quiet();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d words, checked %0d results", words_sent, words_checked);
        $display("overlap %0d, separated %0d, invalid box %0d, mismatches %0d",
                 n_overlap, n_separated, n_invalid, fail_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
